// ----- src/driven_svf_lowpass_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the driven state-variable lowpass block
// Shared property wrappers used by the modules that check their own logic.
// ----------------------------------------------------------------------------
`ifndef DRIVEN_SVF_LOWPASS_TOP_MACROS_SVH
`define DRIVEN_SVF_LOWPASS_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DSVF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DSVF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/dsvf_pkg.sv -----
// ----------------------------------------------------------------------------
// Driven SVF lowpass package
// Types, widths and constants shared by the block's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package dsvf_pkg;

  localparam int SampleW = 24;
  localparam int StateW  = 32;
  localparam int CoefW   = 25;
  localparam int GainW   = 21;
  localparam int CompW   = 18;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 25;
  localparam int FracBits = 19;
  localparam int WideW   = 64;

  localparam logic [CfgIdxW-1:0] RegA1   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegA2   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegA3   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGain = 3'd3;
  localparam logic [CfgIdxW-1:0] RegComp = 3'd4;

  localparam logic [CoefW-1:0] A1Reset   = 25'd8388608;
  localparam logic [CoefW-1:0] A2Reset   = 25'd4194304;
  localparam logic [CoefW-1:0] A3Reset   = 25'd2097152;
  localparam logic [GainW-1:0] GainReset = 21'd65536;
  localparam logic [CompW-1:0] CompReset = 18'd74888;

  localparam int DivW = 32;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GAIN, ST_CLIP0, ST_CLIP1, ST_CLIP2, ST_CLIP3, ST_DIVW, ST_COMP,
    ST_V3, ST_M1, ST_M2, ST_M3, ST_M4, ST_V1, ST_V2, ST_CLIPB0, ST_CLIPB1,
    ST_CLIPB2, ST_CLIPB3, ST_DIVBW, ST_DONE, ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

// ----- src/dsvf_if.sv -----
// ----------------------------------------------------------------------------
// Driven SVF lowpass channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface dsvf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [23:0] sample_in;
  modport source (output valid, action, sample_in, input ready);
  modport sink (input valid, action, sample_in, output ready);
endinterface

interface dsvf_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] lowpass_out;
  modport source (output valid, lowpass_out, input ready);
  modport sink (input valid, lowpass_out, output ready);
endinterface

interface dsvf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [24:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/driven_svf_lowpass_top.sv -----
// ----------------------------------------------------------------------------
// Driven SVF lowpass top level
// Register file, input capture and output register around the shared core.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        action, sample_in
//  out_ch    out  valid/ready        lowpass_out
//  cfg_ch    in   valid/ready        index, data
// A sample passes through two divider waits between its input transfer
// and its result; a clear action goes straight to the output state.
// Input is not ready while the core works.
// The result register frees the core; a stalled output holds the next start.
// Reset clears both integrator states and loads the register defaults.
`timescale 1ns / 1ps
module driven_svf_lowpass_top import dsvf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  dsvf_in_if.sink      in_ch,
  dsvf_out_if.source   out_ch,
  dsvf_cfg_if.sink     cfg_ch
);

  logic [CoefW-1:0] a1_q, a2_q, a3_q;
  logic [GainW-1:0] gain_q;
  logic [CompW-1:0] comp_q;
  logic             ovalid_q;
  logic [SampleW-1:0] odata_q;
  logic             busy, done, start;
  logic signed [SampleW-1:0] result;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy && !ovalid_q;
  assign start        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q <= A1Reset; a2_q <= A2Reset; a3_q <= A3Reset;
      gain_q <= GainReset; comp_q <= CompReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        RegA1:   a1_q <= cfg_ch.data;
        RegA2:   a2_q <= cfg_ch.data;
        RegA3:   a3_q <= cfg_ch.data;
        RegGain: gain_q <= cfg_ch.data[GainW-1:0];
        RegComp: comp_q <= cfg_ch.data[CompW-1:0];
        default: ;
      endcase
    end
  end

  dsvf_core u_core (
    .clk_i, .rst_ni, .start_i(start), .clear_i(in_ch.action),
    .sample_i(in_ch.sample_in), .a1_i(a1_q), .a2_i(a2_q), .a3_i(a3_q),
    .gain_i(gain_q), .comp_i(comp_q), .busy_o(busy), .done_o(done),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (done) ovalid_q <= 1'b1;
    else if (out_ch.ready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done) odata_q <= result;
  end

  assign out_ch.valid       = ovalid_q;
  assign out_ch.lowpass_out = odata_q;

endmodule

// ----- src/dsvf_div.sv -----
// ----------------------------------------------------------------------------
// Driven SVF lowpass divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dsvf_div import dsvf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [WideW-1:0] num_i,
  input  logic        [DivW-1:0] den_i,
  output div_ctl_t               ctl_o,
  output logic signed [WideW-1:0] quo_o
);

  logic [WideW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [DivW-1:0]  den_q, den_d;
  logic             neg_q, neg_d, busy_q, busy_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [WideW:0]   trial;
  logic [WideW-1:0] shrem;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q;
    shrem = {rem_q[WideW-2:0], quo_q[WideW-1]};
    trial = {1'b0, shrem} - {{(WideW-DivW+1){1'b0}}, den_q};
    if (start_i) begin
      neg_d = num_i[WideW-1];
      quo_d = num_i[WideW-1] ? -num_i : num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[WideW]) begin
        rem_d = trial[WideW-1:0];
        quo_d = {quo_q[WideW-2:0], 1'b1};
      end else begin
        rem_d = shrem;
        quo_d = {quo_q[WideW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign quo_o = neg_q ? -quo_q : quo_q;

endmodule

// ----- src/dsvf_core.sv -----
// ----------------------------------------------------------------------------
// Driven SVF lowpass datapath and sequencer
// One shared multiplier and one divider stepped through the drive and filter math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "driven_svf_lowpass_top_macros.svh"
module dsvf_core import dsvf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      clear_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic        [CoefW-1:0]   a1_i,
  input  logic        [CoefW-1:0]   a2_i,
  input  logic        [CoefW-1:0]   a3_i,
  input  logic        [GainW-1:0]   gain_i,
  input  logic        [CompW-1:0]   comp_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic signed [SampleW-1:0] result_o
);

  localparam int MulAW = 26;
  localparam int MulBW = 34;
  localparam int ProdW = MulAW + MulBW;

  localparam logic signed [WideW-1:0] One   = 64'sd1 <<< FracBits;
  localparam logic signed [WideW-1:0] Lim   = 64'sd3 * One;
  localparam logic signed [WideW-1:0] PadeA = 64'sd27 * One;
  localparam logic signed [WideW-1:0] Smax  = 64'sd2147483647;
  localparam logic signed [WideW-1:0] Smin  = -64'sd2147483648;
  localparam logic signed [WideW-1:0] Omax  = 64'sd8388607;
  localparam logic signed [WideW-1:0] Omin  = -64'sd8388608;

  state_e state_q, state_d;
  logic signed [WideW-1:0] x_q, x_d, t_q, t_d, acc_q, acc_d, x2_q, x2_d;
  logic signed [WideW-1:0] v3_q, v3_d, v2_q, v2_d;
  logic signed [StateW-1:0] band_q, band_d, low_q, low_d;
  logic signed [SampleW-1:0] res_q, res_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_n;
  logic signed [WideW-1:0] prod;
  logic                    div_start;
  logic signed [WideW-1:0] div_num, div_quo;
  logic        [DivW-1:0]  div_den;
  div_ctl_t                div_ctl;
  logic signed [WideW-1:0] xc, w;

  dsvf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .ctl_o(div_ctl), .quo_o(div_quo)
  );

  assign prod_n = mul_a * mul_b;
  assign prod   = WideW'(prod_n);

  always_comb begin
    unique case (state_q)
      ST_IDLE:   state_d = start_i ? (clear_i ? ST_OUT : ST_GAIN) : ST_IDLE;
      ST_GAIN:   state_d = ST_CLIP0;
      ST_CLIP0:  state_d = ST_CLIP1;
      ST_CLIP1:  state_d = ST_CLIP2;
      ST_CLIP2:  state_d = ST_CLIP3;
      ST_CLIP3:  state_d = ST_DIVW;
      ST_DIVW:   state_d = (div_ctl.busy || div_ctl.start) ? ST_DIVW : ST_COMP;
      ST_COMP:   state_d = ST_V3;
      ST_V3:     state_d = ST_M1;
      ST_M1:     state_d = ST_M2;
      ST_M2:     state_d = ST_M3;
      ST_M3:     state_d = ST_M4;
      ST_M4:     state_d = ST_V1;
      ST_V1:     state_d = ST_V2;
      ST_V2:     state_d = ST_CLIPB0;
      ST_CLIPB0: state_d = ST_CLIPB1;
      ST_CLIPB1: state_d = ST_CLIPB2;
      ST_CLIPB2: state_d = ST_CLIPB3;
      ST_CLIPB3: state_d = ST_DIVBW;
      ST_DIVBW:  state_d = (div_ctl.busy || div_ctl.start) ? ST_DIVBW : ST_DONE;
      ST_DONE:   state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    x_d = x_q; t_d = t_q; acc_d = acc_q; x2_d = x2_q; v3_d = v3_q; v2_d = v2_q;
    band_d = band_q; low_d = low_q; res_d = res_q;
    mul_a = MulAW'(x_q); mul_b = MulBW'(x_q);
    div_start = 1'b0; div_num = t_q; div_den = acc_q[DivW-1:0];
    xc = (x_q > Lim) ? Lim : ((x_q < -Lim) ? -Lim : x_q);
    w = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d = WideW'(sample_i);
          if (clear_i) begin
            band_d = '0; low_d = '0; res_d = '0;
          end
        end
      end
      ST_GAIN, ST_COMP: begin
        mul_b = (state_q == ST_GAIN) ? MulBW'(gain_i) : MulBW'(comp_i);
        x_d = prod >>> 16;
      end
      ST_CLIP0, ST_CLIPB0: x_d = xc;
      ST_CLIP1, ST_CLIPB1: x2_d = prod >>> FracBits;
      ST_CLIP2, ST_CLIPB2: begin
        mul_b = MulBW'(PadeA + x2_q);
        t_d = prod;
        acc_d = PadeA + 64'sd9 * x2_q;
      end
      ST_CLIP3, ST_CLIPB3: div_start = 1'b1;
      ST_DIVW: x_d = div_quo;
      ST_V3: v3_d = x_q - WideW'(low_q);
      ST_M1: begin
        mul_a = MulAW'(a1_i); mul_b = MulBW'(band_q); acc_d = prod;
      end
      ST_M2: begin
        mul_a = MulAW'(a2_i); mul_b = MulBW'(v3_q); acc_d = (acc_q + prod) >>> 24;
      end
      ST_M3: begin
        mul_a = MulAW'(a2_i); mul_b = MulBW'(band_q); t_d = prod;
      end
      ST_M4: begin
        mul_a = MulAW'(a3_i); mul_b = MulBW'(v3_q);
        v2_d = WideW'(low_q) + ((t_q + prod) >>> 24);
      end
      ST_V1: x_d = (acc_q <<< 1) - WideW'(band_q);
      ST_V2: begin
        w = (v2_q <<< 1) - WideW'(low_q);
        low_d = StateW'((w > Smax) ? Smax : ((w < Smin) ? Smin : w));
        res_d = SampleW'((v2_q > Omax) ? Omax : ((v2_q < Omin) ? Omin : v2_q));
      end
      ST_DIVBW: band_d = StateW'(div_quo);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      band_q  <= '0;
      low_q   <= '0;
    end else begin
      state_q <= state_d;
      band_q  <= band_d;
      low_q   <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; t_q <= t_d; acc_q <= acc_d; x2_q <= x2_d;
    v3_q <= v3_d; v2_q <= v2_d; res_q <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_OUT);
  assign result_o = res_q;

  `DSVF_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, (state_q == ST_IDLE) && start_i, busy_o)
  `DSVF_ASSERT_IMP(a_div_in_wait, clk_i, rst_ni, div_ctl.busy,
                   (state_q == ST_DIVW) || (state_q == ST_DIVBW))
  `DSVF_ASSERT_NEXT(a_clear_zero, clk_i, rst_ni, (state_q == ST_IDLE) && start_i && clear_i,
                    (band_q == '0) && (low_q == '0) && done_o)

endmodule
